/* rtl/tt_pkg.sv */
// Shared types and constants for the triangle tangent block.
// Word layouts, internal widths and handshake structs; no dependencies.
`default_nettype none

package tt_pkg;

    localparam int WORD_W = 32;            // Q16.16 word
    localparam int FRAC_W = 16;            // fraction bits of a Q16.16 word
    localparam int DIFF_W = WORD_W + 1;    // exact difference of two words
    localparam int PROD_W = 2 * DIFF_W;    // exact product of two differences
    localparam int ACC_W  = PROD_W + 1;    // difference of two products
    localparam int CNT_W  = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] Q_MAX_POS = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] Q_MIN_MAG = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic signed [WORD_W-1:0] tex_u;
        logic signed [WORD_W-1:0] tex_v;
    } vtx_word_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] tangent_x;
        logic signed [WORD_W-1:0] tangent_y;
        logic signed [WORD_W-1:0] tangent_z;
        logic                     degenerate;
    } tan_word_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] num;
        logic signed [ACC_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] quo;
    } div_rsp_t;

    function automatic logic signed [DIFF_W-1:0] sdiff(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        return {a[WORD_W-1], a} - {b[WORD_W-1], b};
    endfunction

endpackage

`default_nettype wire

/* rtl/tt_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on tt_pkg for the operand struct and widths.
`default_nettype none

module tt_mul (
    input  logic                            clk,
    input  tt_pkg::mul_req_t                req,
    output logic signed [tt_pkg::PROD_W-1:0] prod
);
    import tt_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(req.a * req.b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/tt_div.sv */
// Restoring divider: (num * 2^16) / den, truncated, saturated to a Q16.16 word.
// One quotient bit per cycle after an overflow check. Depends on tt_pkg.
`default_nettype none

module tt_div (
    input  logic             clk,
    input  logic             rst_n,
    input  tt_pkg::div_req_t req,
    output tt_pkg::div_rsp_t rsp
);
    import tt_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_ITER, D_FIX} dstate_t;

    dstate_t            state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic               neg_reg;
    logic               sat_reg;
    logic [ACC_W-1:0]   nmag_reg;
    logic [ACC_W-1:0]   dmag_reg;
    logic [ACC_W-1:0]   rem_reg;
    logic [WORD_W-1:0]  sh_reg;
    logic [WORD_W-1:0]  q_reg;
    logic [WORD_W-1:0]  quo_reg;

    logic [ACC_W-1:0]   num_mag;
    logic [ACC_W-1:0]   den_mag;
    logic               sat_check;
    logic [ACC_W:0]     shifted;
    logic [ACC_W+1:0]   trial;
    logic               fits;
    logic [WORD_W-1:0]  limit;
    logic [WORD_W-1:0]  mag;

    assign num_mag = req.num[ACC_W-1] ? ACC_W'(-req.num) : ACC_W'(req.num);
    assign den_mag = req.den[ACC_W-1] ? ACC_W'(-req.den) : ACC_W'(req.den);

    // quotient >= 2^32 exactly when (num >> 16) >= den
    assign sat_check = {{FRAC_W{1'b0}}, nmag_reg[ACC_W-1:FRAC_W]} >= dmag_reg;

    assign shifted = {rem_reg, sh_reg[WORD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dmag_reg};
    assign fits    = !trial[ACC_W+1];

    assign limit = neg_reg ? Q_MIN_MAG : Q_MAX_POS;
    assign mag   = (sat_reg || (q_reg > limit)) ? limit : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == D_FIX);
            case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                        state_reg <= D_CHECK;
                end
                D_CHECK:
                begin
                    cnt_reg   <= CNT_W'(WORD_W - 1);
                    state_reg <= sat_check ? D_FIX : D_ITER;
                end
                D_ITER:
                begin
                    if (cnt_reg == '0)
                        state_reg <= D_FIX;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                D_FIX:
                begin
                    state_reg <= D_IDLE;
                end
                default:
                    state_reg <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && req.start)
        begin
            neg_reg  <= req.num[ACC_W-1] ^ req.den[ACC_W-1];
            nmag_reg <= num_mag;
            dmag_reg <= den_mag;
        end
        if (state_reg == D_CHECK)
        begin
            sat_reg <= sat_check;
            rem_reg <= {{FRAC_W{1'b0}}, nmag_reg[ACC_W-1:FRAC_W]};
            sh_reg  <= {nmag_reg[FRAC_W-1:0], {(WORD_W-FRAC_W){1'b0}}};
            q_reg   <= '0;
        end
        if (state_reg == D_ITER)
        begin
            rem_reg <= fits ? trial[ACC_W-1:0] : shifted[ACC_W-1:0];
            sh_reg  <= {sh_reg[WORD_W-2:0], 1'b0};
            q_reg   <= {q_reg[WORD_W-2:0], fits};
        end
        if (state_reg == D_FIX)
            quo_reg <= neg_reg ? WORD_W'(-mag) : mag;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == D_IDLE)
        else $error("divider started while busy");

    a_fix_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == D_FIX |=> rsp.done && state_reg == D_IDLE)
        else $error("divider finish not signaled");
`endif

endmodule

`default_nettype wire

/* rtl/triangle_tangent_compute_core.sv */
// Triangle tangent core: one vertex word in, one tangent word per triangle out.
// First and second corners are accepted on consecutive cycles. The third corner stalls
// the input while the determinant is formed, then per component a multiply-subtract
// and a divide (one quotient bit a cycle); tan_valid rises on the return to idle.
// A saturating component skips the quotient bits; a zero determinant skips the components.
// A stalled output word holds the finish state. Reset (rst_n, async, active low) empties
// the corner count and the output register.
`default_nettype none

module triangle_tangent_compute_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vtx_valid,
    output logic              vtx_stall,
    input  tt_pkg::vtx_word_t vtx_data,
    output logic              tan_valid,
    input  logic              tan_stall,
    output tt_pkg::tan_word_t tan_data
);
    import tt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_EVAL, S_DIV, S_DONE
    } state_t;

    localparam logic [1:0] COMP_DET = 2'd0;
    localparam logic [1:0] COMP_X   = 2'd1;
    localparam logic [1:0] COMP_Y   = 2'd2;
    localparam logic [1:0] COMP_Z   = 2'd3;

    localparam logic [1:0] CORNER_NONE = 2'd0;
    localparam logic [1:0] CORNER_ONE  = 2'd1;
    localparam logic [1:0] CORNER_TWO  = 2'd2;

    state_t                   state_reg;
    logic [1:0]               corner_reg;
    logic [1:0]               comp_reg;
    logic                     out_valid_reg;

    logic signed [WORD_W-1:0] p0_reg [3];
    logic signed [WORD_W-1:0] t0_reg [2];
    logic signed [WORD_W-1:0] p1_reg [3];
    logic signed [WORD_W-1:0] t1_reg [2];
    logic signed [DIFF_W-1:0] e1_reg [3];
    logic signed [DIFF_W-1:0] e2_reg [3];
    logic signed [DIFF_W-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  det_reg;
    logic signed [WORD_W-1:0] tan_reg [3];
    logic                     deg_reg;
    tan_word_t                out_word_reg;

    logic                     vtx_accept;
    logic                     load_out;
    logic signed [DIFF_W-1:0] e1_sel, e2_sel;
    mul_req_t                 mul_req;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;
    logic signed [DIFF_W-1:0] p2_d [3];

    assign vtx_stall  = state_reg != S_IDLE;
    assign vtx_accept = vtx_valid && (state_reg == S_IDLE);
    assign load_out   = (state_reg == S_DONE) && (!out_valid_reg || !tan_stall);
    assign tan_valid  = out_valid_reg;
    assign tan_data   = out_word_reg;

    assign p2_d[0] = sdiff(vtx_data.pos_x, p1_reg[0]);
    assign p2_d[1] = sdiff(vtx_data.pos_y, p1_reg[1]);
    assign p2_d[2] = sdiff(vtx_data.pos_z, p1_reg[2]);

    always_comb
    begin
        case (comp_reg)
            COMP_X:
            begin
                e1_sel = e1_reg[0];
                e2_sel = e2_reg[0];
            end
            COMP_Y:
            begin
                e1_sel = e1_reg[1];
                e2_sel = e2_reg[1];
            end
            default:
            begin
                e1_sel = e1_reg[2];
                e2_sel = e2_reg[2];
            end
        endcase

        // first term in S_MUL0, subtracted term in S_MUL1
        if (comp_reg == COMP_DET)
        begin
            mul_req.a = (state_reg == S_MUL1) ? du2_reg : du1_reg;
            mul_req.b = (state_reg == S_MUL1) ? dv1_reg : dv2_reg;
        end
        else
        begin
            mul_req.a = (state_reg == S_MUL1) ? dv1_reg : dv2_reg;
            mul_req.b = (state_reg == S_MUL1) ? e2_sel  : e1_sel;
        end
    end

    tt_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign prod_ext = {prod[PROD_W-1], prod};

    assign div_req.start = (state_reg == S_EVAL) && (comp_reg != COMP_DET);
    assign div_req.num   = acc_reg;
    assign div_req.den   = det_reg;

    tt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            corner_reg    <= CORNER_NONE;
            comp_reg      <= COMP_DET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!tan_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (vtx_valid)
                    begin
                        case (corner_reg)
                            CORNER_ONE:
                                corner_reg <= CORNER_TWO;
                            CORNER_TWO:
                            begin
                                corner_reg <= CORNER_NONE;
                                comp_reg   <= COMP_DET;
                                state_reg  <= S_MUL0;
                            end
                            default:
                                corner_reg <= CORNER_ONE;
                        endcase
                    end
                end
                S_MUL0:
                    state_reg <= S_MUL1;
                S_MUL1:
                    state_reg <= S_MUL2;
                S_MUL2:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (comp_reg != COMP_DET)
                        state_reg <= S_DIV;
                    else if (acc_reg == '0)
                        state_reg <= S_DONE;
                    else
                    begin
                        comp_reg  <= COMP_X;
                        state_reg <= S_MUL0;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (comp_reg == COMP_Z)
                            state_reg <= S_DONE;
                        else
                        begin
                            comp_reg  <= comp_reg + 1'b1;
                            state_reg <= S_MUL0;
                        end
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (vtx_accept)
        begin
            case (corner_reg)
                CORNER_ONE:
                begin
                    p1_reg[0] <= vtx_data.pos_x;
                    p1_reg[1] <= vtx_data.pos_y;
                    p1_reg[2] <= vtx_data.pos_z;
                    t1_reg[0] <= vtx_data.tex_u;
                    t1_reg[1] <= vtx_data.tex_v;
                end
                CORNER_TWO:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        e1_reg[k] <= sdiff(p0_reg[k], p1_reg[k]);
                        e2_reg[k] <= p2_d[k];
                    end
                    du1_reg <= sdiff(t0_reg[0], t1_reg[0]);
                    dv1_reg <= sdiff(t0_reg[1], t1_reg[1]);
                    du2_reg <= sdiff(vtx_data.tex_u, t1_reg[0]);
                    dv2_reg <= sdiff(vtx_data.tex_v, t1_reg[1]);
                end
                default:
                begin
                    p0_reg[0] <= vtx_data.pos_x;
                    p0_reg[1] <= vtx_data.pos_y;
                    p0_reg[2] <= vtx_data.pos_z;
                    t0_reg[0] <= vtx_data.tex_u;
                    t0_reg[1] <= vtx_data.tex_v;
                end
            endcase
        end

        if (state_reg == S_MUL1)
            acc_reg <= prod_ext;
        if (state_reg == S_MUL2)
            acc_reg <= acc_reg - prod_ext;

        if (state_reg == S_EVAL && comp_reg == COMP_DET)
        begin
            det_reg <= acc_reg;
            deg_reg <= acc_reg == '0;
        end

        if (state_reg == S_DIV && div_rsp.done)
        begin
            case (comp_reg)
                COMP_X:  tan_reg[0] <= div_rsp.quo;
                COMP_Y:  tan_reg[1] <= div_rsp.quo;
                default: tan_reg[2] <= div_rsp.quo;
            endcase
        end

        if (load_out)
        begin
            out_word_reg.tangent_x  <= deg_reg ? '0 : tan_reg[0];
            out_word_reg.tangent_y  <= deg_reg ? '0 : tan_reg[1];
            out_word_reg.tangent_z  <= deg_reg ? '0 : tan_reg[2];
            out_word_reg.degenerate <= deg_reg;
        end
    end

`ifndef SYNTHESIS
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tan_valid && tan_data.degenerate |->
            tan_data.tangent_x == '0 && tan_data.tangent_y == '0
            && tan_data.tangent_z == '0)
        else $error("degenerate word with nonzero tangent");

    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        corner_reg != 2'd3)
        else $error("corner count out of range");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tan_valid) |-> $past(state_reg == S_DONE))
        else $error("output word loaded outside finish");
`endif

endmodule

`default_nettype wire

/* dv/tb_triangle_tangent_compute_core.sv */
// Self-checking bench for triangle_tangent_compute_core: vertex words in, tangent words out.
// Uses tt_pkg word types; predicts each tangent in exact wide integer arithmetic.
module tb_triangle_tangent_compute_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tt_pkg::*;

    localparam int DIR_ROWS    = 21;
    localparam int RAND_PHASE  = 450;    // vertex words per handshake phase
    localparam int NUM_PHASES  = 4;
    localparam int DRAIN_WAIT  = 300;    // idle wait after the last expected word, to catch stray words
    localparam int MAX_REPORTS = 10;

    localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
    localparam logic signed [127:0] SAT_LO = -128'sd2147483648;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      vtx_valid = 1'b0;
    logic      vtx_stall;
    vtx_word_t vtx_data = '0;
    logic      tan_valid;
    logic      tan_stall = 1'b0;
    tan_word_t tan_data;

    triangle_tangent_compute_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx_data  (vtx_data),
        .tan_valid (tan_valid),
        .tan_stall (tan_stall),
        .tan_data  (tan_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state: corners held for the triangle in progress
    logic [1:0]         held_corners;
    logic signed [31:0] corner0_pos [3];
    logic signed [31:0] corner0_tex [2];
    logic signed [31:0] corner1_pos [3];
    logic signed [31:0] corner1_tex [2];

    tan_word_t tangent_queue [$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatch_count = 0;
    int words_sent = 0;
    int tangents_seen = 0;
    int degenerate_seen = 0;

    // directed stimulus table
    vtx_word_t dir_word [DIR_ROWS];
    bit        dir_typed [DIR_ROWS];
    tan_word_t dir_tangent [DIR_ROWS];

    // random generator bookkeeping
    int                 gen_corner = 0;
    logic signed [31:0] gen_tex0 [2];
    logic signed [31:0] gen_tex1 [2];

    function automatic vtx_word_t mk_vtx(
        input logic [31:0] px,
        input logic [31:0] py,
        input logic [31:0] pz,
        input logic [31:0] tu,
        input logic [31:0] tv
    );
        vtx_word_t w;
        w.pos_x = px;
        w.pos_y = py;
        w.pos_z = pz;
        w.tex_u = tu;
        w.tex_v = tv;
        return w;
    endfunction

    function automatic tan_word_t mk_tan(
        input logic [31:0] tx,
        input logic [31:0] ty,
        input logic [31:0] tz,
        input logic        degen
    );
        tan_word_t t;
        t.tangent_x = tx;
        t.tangent_y = ty;
        t.tangent_z = tz;
        t.degenerate = degen;
        return t;
    endfunction

    function automatic logic [31:0] sat_q16(input logic signed [127:0] q);
        if (q > SAT_HI)
            return 32'h7FFF_FFFF;
        if (q < SAT_LO)
            return 32'h8000_0000;
        return q[31:0];
    endfunction

    // Takes one vertex word; returns 1 and the tangent when it closes a triangle.
    function automatic bit take_corner(input vtx_word_t w, output tan_word_t t);
        logic signed [31:0]  pos [3];
        logic signed [32:0]  e1 [3];
        logic signed [32:0]  e2 [3];
        logic signed [32:0]  du1, dv1, du2, dv2;
        logic signed [127:0] det, num, quo;
        logic [31:0]         comp [3];
        pos[0] = w.pos_x;
        pos[1] = w.pos_y;
        pos[2] = w.pos_z;
        t = '0;
        if (held_corners == 2'd1)
        begin
            corner1_pos = pos;
            corner1_tex[0] = w.tex_u;
            corner1_tex[1] = w.tex_v;
            held_corners = 2'd2;
            return 1'b0;
        end
        if (held_corners != 2'd2)
        begin
            corner0_pos = pos;
            corner0_tex[0] = w.tex_u;
            corner0_tex[1] = w.tex_v;
            held_corners = 2'd1;
            return 1'b0;
        end
        held_corners = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = corner0_pos[k] - corner1_pos[k];
            e2[k] = pos[k] - corner1_pos[k];
        end
        du1 = corner0_tex[0] - corner1_tex[0];
        dv1 = corner0_tex[1] - corner1_tex[1];
        du2 = w.tex_u - corner1_tex[0];
        dv2 = w.tex_v - corner1_tex[1];
        det = du1 * dv2 - du2 * dv1;
        if (det == 0)
        begin
            t.degenerate = 1'b1;
            return 1'b1;
        end
        for (int k = 0; k < 3; k++)
        begin
            num = dv2 * e1[k] - dv1 * e2[k];
            quo = (num <<< 16) / det;   // signed divide truncates toward zero
            comp[k] = sat_q16(quo);
        end
        t.tangent_x = comp[0];
        t.tangent_y = comp[1];
        t.tangent_z = comp[2];
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_field();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'(int'($urandom_range(524287)) - 262144);
            4, 5:       return 32'(int'($urandom_range(33554431)) - 16777216);
            6, 7:       return $urandom;
            default:
            begin
                case ($urandom_range(4))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
        endcase
    endfunction

    // Random vertex; third corners now and then repeat a texcoord to hit a zero determinant.
    function automatic vtx_word_t rand_vertex();
        vtx_word_t w;
        int pick;
        w = mk_vtx(rand_field(), rand_field(), rand_field(), rand_field(), rand_field());
        pick = $urandom_range(99);
        if (gen_corner == 2 && pick < 8)
        begin
            w.tex_u = gen_tex1[0];
            w.tex_v = gen_tex1[1];
        end
        else if (gen_corner == 2 && pick < 14)
        begin
            w.tex_u = gen_tex0[0];
            w.tex_v = gen_tex0[1];
        end
        if (gen_corner == 0)
        begin
            gen_tex0[0] = w.tex_u;
            gen_tex0[1] = w.tex_v;
        end
        else if (gen_corner == 1)
        begin
            gen_tex1[0] = w.tex_u;
            gen_tex1[1] = w.tex_v;
        end
        gen_corner = (gen_corner == 2) ? 0 : gen_corner + 1;
        return w;
    endfunction

    task automatic send_vertex(input vtx_word_t w, input bit typed, input tan_word_t typed_tan);
        tan_word_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            vtx_valid <= 1'b0;
            @(negedge clk);
        end
        vtx_valid <= 1'b1;
        vtx_data <= w;
        do
            @(posedge clk);
        while (vtx_stall !== 1'b0);
        words_sent++;
        if (take_corner(w, predicted))
            tangent_queue.insert(tangent_queue.size(), typed ? typed_tan : predicted);
    endtask

    always @(negedge clk)
        tan_stall <= ($urandom_range(99) < receiver_stall_pct);

    always @(posedge clk)
    begin
        tan_word_t want;
        if (rst_n && tan_valid === 1'b1 && tan_stall === 1'b0)
        begin
            tangents_seen++;
            if (tangent_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected tangent word %h", tan_data);
            end
            else
            begin
                want = tangent_queue.pop_front();
                if (want.degenerate)
                    degenerate_seen++;
                if (tan_data.tangent_x !== want.tangent_x
                    || tan_data.tangent_y !== want.tangent_y
                    || tan_data.tangent_z !== want.tangent_z
                    || tan_data.degenerate !== want.degenerate)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("tangent %0d: exp x=%h y=%h z=%h d=%b, got x=%h y=%h z=%h d=%b",
                                 tangents_seen, want.tangent_x, want.tangent_y,
                                 want.tangent_z, want.degenerate, tan_data.tangent_x,
                                 tan_data.tangent_y, tan_data.tangent_z, tan_data.degenerate);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d tangent words outstanding", tangent_queue.size());
        $display("triangle_tangent_compute_core: mismatch");
        $finish;
    end

    initial
    begin
        held_corners = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            corner0_pos[k] = '0;
            corner1_pos[k] = '0;
        end
        for (int k = 0; k < 2; k++)
        begin
            corner0_tex[k] = '0;
            corner1_tex[k] = '0;
            gen_tex0[k] = '0;
            gen_tex1[k] = '0;
        end
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            dir_typed[i] = 1'b0;
            dir_tangent[i] = '0;
        end

        // unit UV gradients along u: tangent equals P0 - P1
        dir_word[0]  = mk_vtx(32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 0);
        dir_word[1]  = mk_vtx(0, 0, 0, 0, 0);
        dir_word[2]  = mk_vtx(32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 0, 32'h0001_0000);
        dir_typed[2] = 1'b1;
        dir_tangent[2] = mk_tan(32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0);
        // all texcoords equal: zero determinant
        dir_word[3]  = mk_vtx(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF);
        dir_word[4]  = mk_vtx(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        dir_word[5]  = mk_vtx(32'hFFFF_FFFF, 1, 32'h4000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        dir_typed[5] = 1'b1;
        dir_tangent[5] = mk_tan(0, 0, 0, 1'b1);
        // tiny determinant, full-range edge: x and y each saturate on their own, z is zero
        dir_word[6]  = mk_vtx(32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 0);
        dir_word[7]  = mk_vtx(0, 0, 0, 0, 0);
        dir_word[8]  = mk_vtx(0, 0, 0, 0, 1);
        dir_typed[8] = 1'b1;
        dir_tangent[8] = mk_tan(32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0);
        // widest differences in most fields (dv2 and the y of P2 - P1 are zero)
        dir_word[9]  = mk_vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h8000_0000);
        dir_word[10] = mk_vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h7FFF_FFFF);
        dir_word[11] = mk_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // third texcoord repeats the first: collinear UVs, zero determinant
        dir_word[12] = mk_vtx(32'h0000_1000, 32'h0000_2000, 32'h0000_3000,
                              32'h0002_0000, 32'hFFFD_0000);
        dir_word[13] = mk_vtx(0, 0, 0, 32'h0001_0000, 32'h0001_0000);
        dir_word[14] = mk_vtx(32'h0100_0000, 32'hFF00_0000, 5, 32'h0002_0000, 32'hFFFD_0000);
        dir_typed[14] = 1'b1;
        dir_tangent[14] = mk_tan(0, 0, 0, 1'b1);
        // negative determinant: tangent equals P2 - P1
        dir_word[15] = mk_vtx(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 0, 32'h0001_0000);
        dir_word[16] = mk_vtx(0, 0, 0, 0, 0);
        dir_word[17] = mk_vtx(32'hFFFF_FFFB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0);
        dir_typed[17] = 1'b1;
        dir_tangent[17] = mk_tan(32'hFFFF_FFFB, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        // odd ratios: quotient truncation toward zero, both signs
        dir_word[18] = mk_vtx(32'h0000_7001, 32'hFFFF_8FFF, 32'h0001_2345, 32'h0003_0000, 7);
        dir_word[19] = mk_vtx(32'hFFFF_F000, 32'h0000_0123, 32'hFFFE_0000, 32'hFFFF_FFFD, 2);
        dir_word[20] = mk_vtx(32'h0002_0001, 32'hFFFC_0003, 32'h0000_0777, 11, 32'hFFF9_0000);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_vertex(dir_word[i], dir_typed[i], dir_tangent[i]);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
                default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
            endcase
            for (int i = 0; i < RAND_PHASE; i++)
                send_vertex(rand_vertex(), 1'b0, '0);
        end

        @(negedge clk);
        vtx_valid <= 1'b0;
        while (tangent_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d vertex words sent, %0d tangent words checked (%0d degenerate)",
                 words_sent, tangents_seen, degenerate_seen);
        $display("phases: free-running, sender gaps, receiver stalls, both; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && tangent_queue.size() == 0)
            $display("triangle_tangent_compute_core: match");
        else
            $display("triangle_tangent_compute_core: mismatch");
        $finish;
    end

endmodule

/* sim.f */
rtl/tt_pkg.sv
rtl/tt_mul.sv
rtl/tt_div.sv
rtl/triangle_tangent_compute_core.sv
dv/tb_triangle_tangent_compute_core.sv
